// File: src/plt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table package
// Shared command and status codes, payload structs and the per-cell control
// bundle for the positional list table.
// ----------------------------------------------------------------------------
package plt_pkg;

  localparam int unsigned CmdWidth    = 3;
  localparam int unsigned PosWidth    = 8;
  localparam int unsigned DataWidth   = 32;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [CmdWidth-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_OVERWRITE = 3'd2,
    CMD_READ      = 3'd3,
    CMD_FIND      = 3'd4,
    CMD_CLEAR     = 3'd5
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK       = 2'd0,
    ST_BADPOS   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [CmdWidth-1:0]         command;
    logic [PosWidth-1:0]         position;
    logic signed [DataWidth-1:0] value;
  } plt_in_t;

  typedef struct packed {
    logic [StatusWidth-1:0]      status;
    logic signed [DataWidth-1:0] read_value;
    logic [PosWidth-1:0]         found_position;
    logic [PosWidth-1:0]         item_count;
    logic                        is_empty;
  } plt_out_t;

  // Broadcast to every cell; each cell decides from its own index what to do.
  typedef struct packed {
    logic ins;
    logic del;
    logic wr;
  } plt_cell_op_t;

endpackage

// File: src/plt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table cell
// Holds one list entry, shifts it to or from its neighbors and compares it
// against the search key.
// ----------------------------------------------------------------------------
module plt_cell #(
  parameter int unsigned VW  = 32,
  parameter int unsigned IW  = 7,
  parameter int unsigned CW  = 8,
  parameter int unsigned IDX = 0
) (
  input  logic                 clk_i,
  input  plt_pkg::plt_cell_op_t op_i,
  input  logic [IW-1:0]        pos_idx_i,
  input  logic [CW-1:0]        count_i,
  input  logic [VW-1:0]        left_i,
  input  logic [VW-1:0]        right_i,
  input  logic [VW-1:0]        new_i,
  input  logic [VW-1:0]        key_i,
  output logic [VW-1:0]        data_o,
  output logic                 match_o
);
  import plt_pkg::*;

  localparam logic [IW-1:0] MyIdx = IW'(IDX);
  localparam logic [CW-1:0] MyCnt = CW'(IDX);

  logic [VW-1:0] data_q, data_d;
  logic          at_pos, after_pos;

  assign at_pos    = (MyIdx == pos_idx_i);
  assign after_pos = (MyIdx > pos_idx_i);

  always_comb begin
    data_d = data_q;
    if (op_i.ins && at_pos) begin
      data_d = new_i;
    end else if (op_i.ins && after_pos) begin
      data_d = left_i;
    end else if (op_i.del && (at_pos || after_pos)) begin
      data_d = right_i;
    end else if (op_i.wr && at_pos) begin
      data_d = new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Only entries inside the occupied part of the list may match.
  assign match_o = (MyCnt < count_i) && (data_q == key_i);
  assign data_o  = data_q;

endmodule

// File: src/positional_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table
// Bounded ordered list of signed values with insert, delete, overwrite,
// read, find and clear commands, built as a chain of storage cells.
// ----------------------------------------------------------------------------
// Every command passes through the sequencer states in order: idle, in which
// its input transfer registers the command, execute, in which all cells
// shift, write and compare in parallel, and resolve, in which the lowest
// matching cell is picked out and the result is built. Resolve waits until
// the output register is free or is being emptied. A new command is taken
// only once the previous one has left resolve, so the block does not take a
// new command before it is through with the last one. The result sits in an
// output register, so the next command can be taken while an earlier result
// still waits for its transfer. Entries live one per cell; an insert moves
// every cell at or beyond the position one place up, a delete moves them one
// place down, and a find compares every occupied cell against the key at
// once. Positions are 1-based. Entries beyond the current count are never
// visible, and the cells carry no reset.
// ----------------------------------------------------------------------------
module positional_list_table #(
  parameter int unsigned CAPACITY    = 128,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  plt_pkg::plt_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output plt_pkg::plt_out_t out_data_o
);
  import plt_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  // Width wide enough to compare a position against count + 1.
  localparam int unsigned MW = (CW + 1 > PosWidth) ? CW + 1 : PosWidth;
  localparam logic [CW-1:0] FullCount = CW'(CAPACITY);

  // One-hot sequencer: take command, run the cells, resolve the result.
  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_EXEC    = 3'b010,
    S_RESOLVE = 3'b100
  } state_e;

  state_e state_q, state_d;

  plt_in_t          cmd_q;
  logic [CW-1:0]    count_q, count_d;
  logic [1:0]       status_q, status_d;
  logic [VALUE_WIDTH-1:0] rd_q, rd_d;
  logic [CAPACITY-1:0]    match_q;
  logic             out_valid_q, out_valid_d;
  plt_out_t         out_q, out_d;

  // Command decode during the execute cycle.
  logic [PosWidth-1:0]     pos_m1;
  logic [IW-1:0]           pos_idx;
  logic [MW-1:0]           pos_w, cnt_w, cnt_p1_w;
  logic                    pos_nz, ins_in_range, in_range, full;
  logic [VALUE_WIDTH-1:0]  new_val;
  plt_cell_op_t            cell_op;

  logic [VALUE_WIDTH-1:0]  cell_data [CAPACITY];
  logic [CAPACITY-1:0]     cell_match;

  logic                    any_match;
  logic [IW-1:0]           found_idx;
  logic [IW:0]             found_pos;
  logic                    resolve_done;

  assign pos_m1       = cmd_q.position - PosWidth'(1);
  assign pos_idx      = IW'(pos_m1);
  assign pos_w        = MW'(cmd_q.position);
  assign cnt_w        = MW'(count_q);
  assign cnt_p1_w     = cnt_w + MW'(1);
  assign pos_nz       = (cmd_q.position != '0);
  assign ins_in_range = pos_nz && (pos_w <= cnt_p1_w);
  assign in_range     = pos_nz && (pos_w <= cnt_w);
  assign full         = (count_q == FullCount);
  // The stored form is the input sign-extended or cut to the entry width.
  assign new_val      = VALUE_WIDTH'(cmd_q.value);

  always_comb begin
    cell_op  = '0;
    count_d  = count_q;
    status_d = status_q;
    rd_d     = rd_q;
    if (state_q == S_EXEC) begin
      status_d = ST_OK;
      rd_d     = '0;
      case (cmd_q.command)
        CMD_INSERT: begin
          if (!ins_in_range) begin
            status_d = ST_BADPOS;
          end else if (full) begin
            status_d = ST_FULL;
          end else begin
            cell_op.ins = 1'b1;
            count_d     = count_q + CW'(1);
          end
        end
        CMD_DELETE: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            cell_op.del = 1'b1;
            count_d     = count_q - CW'(1);
          end
        end
        CMD_OVERWRITE: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            cell_op.wr = 1'b1;
          end
        end
        CMD_READ: begin
          if (!in_range) begin
            status_d = ST_BADPOS;
          end else begin
            rd_d = cell_data[pos_idx];
          end
        end
        CMD_FIND: begin
          // Final status is settled once the match vector is resolved.
          status_d = ST_NOTFOUND;
        end
        CMD_CLEAR: begin
          count_d = '0;
        end
        default: begin
          status_d = ST_BADPOS;
        end
      endcase
    end
  end

  // The chain of cells. Each cell sees its neighbors' contents so that
  // inserts and deletes become a parallel shift across the whole row.
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_data, right_data;
    if (k == 0) begin : g_first
      assign left_data = '0;
    end else begin : g_mid_l
      assign left_data = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_data = '0;
    end else begin : g_mid_r
      assign right_data = cell_data[k+1];
    end

    plt_cell #(
      .VW (VALUE_WIDTH),
      .IW (IW),
      .CW (CW),
      .IDX(k)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (cell_op),
      .pos_idx_i(pos_idx),
      .count_i  (count_q),
      .left_i   (left_data),
      .right_i  (right_data),
      .new_i    (new_val),
      .key_i    (new_val),
      .data_o   (cell_data[k]),
      .match_o  (cell_match[k])
    );
  end

  // Lowest matching position, taken from the registered match vector.
  always_comb begin
    found_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match_q[k]) begin
        found_idx = IW'(k);
      end
    end
  end

  assign any_match = |match_q;
  assign found_pos = {1'b0, found_idx} + {{IW{1'b0}}, 1'b1};

  // The result is loaded only when the output register is free or is being
  // emptied in this same cycle.
  assign resolve_done = (state_q == S_RESOLVE) && (!out_valid_q || out_ready_i);

  always_comb begin
    out_d                = out_q;
    out_valid_d          = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (resolve_done) begin
      out_valid_d          = 1'b1;
      out_d.status         = status_q;
      out_d.read_value     = DataWidth'($signed(rd_q));
      out_d.found_position = '0;
      out_d.item_count     = PosWidth'(count_q);
      out_d.is_empty       = (count_q == '0);
      if ((cmd_q.command == CMD_FIND) && any_match) begin
        out_d.status         = ST_OK;
        out_d.found_position = PosWidth'(found_pos);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_RESOLVE;
      end
      S_RESOLVE: begin
        if (resolve_done) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= in_data_i;
    end
    status_q <= status_d;
    rd_q     <= rd_d;
    if (state_q == S_EXEC) begin
      match_q <= cell_match;
    end
    out_q <= out_d;
  end

`ifndef SYNTHESIS
  // A command occupies the sequencer, so no second transfer directly follows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a command was still running");

  // The count never grows past the number of cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FullCount)
    else $error("entry count exceeds capacity");

  // Read data and found position stay zero in any failing result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.read_value == '0) && (out_data_o.found_position == '0))
    else $error("failing result carries data");

  // The empty flag follows the count that the result reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    resolve_done |=> out_data_o.is_empty == (count_q == '0))
    else $error("empty flag disagrees with entry count");
`endif

endmodule

// File: test/tb_positional_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table testbench
// Drives list commands through the input handshake and keeps its own shadow
// copy of the list to predict every result. Each result transfer is checked
// field by field against the oldest prediction. The run covers directed
// corner cases, a fill to capacity, a long output stall and random command
// mixes under varying idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_positional_list_table;
  import plt_pkg::*;

  localparam int unsigned ListDepth      = 128;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned DrainCycles    = 12;
  localparam int unsigned MaxSendGap     = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  plt_in_t   in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  plt_out_t  out_data_o;

  // Shadow copy of the list. Only entries below shadow_count are ever looked
  // at, so the entries above it need no initial value.
  logic [DataWidth-1:0] shadow_list [ListDepth];
  int unsigned          shadow_count;

  // Results predicted for accepted commands, oldest first.
  plt_out_t owed_results [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;

  // Per-cycle idle chances (percent) for the sender and the receiver, and a
  // request counter that asks the receiver for one long hold-off.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_requests;

  positional_list_table #(
    .CAPACITY   (ListDepth),
    .VALUE_WIDTH(DataWidth)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 2 ns clock period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Applies one command to the shadow list and returns the result that the
  // block must produce for it. Unknown commands fall through to bad position.
  function automatic plt_out_t apply_list_command(input plt_in_t item);
    plt_out_t    res;
    int unsigned pos;
    int unsigned k;
    res = '0;
    pos = item.position;
    case (item.command)
      CMD_INSERT: begin
        if (pos < 1 || pos > shadow_count + 1) begin
          res.status = ST_BADPOS;
        end else if (shadow_count >= ListDepth) begin
          // The position check wins over the capacity check.
          res.status = ST_FULL;
        end else begin
          for (k = shadow_count; k >= pos; k--) begin
            shadow_list[k] = shadow_list[k-1];
          end
          shadow_list[pos-1] = item.value;
          shadow_count++;
          res.status = ST_OK;
        end
      end
      CMD_DELETE: begin
        if (pos < 1 || pos > shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          for (k = pos; k < shadow_count; k++) begin
            shadow_list[k-1] = shadow_list[k];
          end
          shadow_count--;
          res.status = ST_OK;
        end
      end
      CMD_OVERWRITE: begin
        if (pos < 1 || pos > shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          shadow_list[pos-1] = item.value;
          res.status = ST_OK;
        end
      end
      CMD_READ: begin
        if (pos < 1 || pos > shadow_count) begin
          res.status = ST_BADPOS;
        end else begin
          res.read_value = shadow_list[pos-1];
          res.status = ST_OK;
        end
      end
      CMD_FIND: begin
        // The lowest matching position wins; an empty list never matches.
        res.status = ST_NOTFOUND;
        for (k = 0; k < shadow_count; k++) begin
          if (shadow_list[k] == item.value) begin
            res.found_position = 8'(k + 1);
            res.status = ST_OK;
            break;
          end
        end
      end
      CMD_CLEAR: begin
        shadow_count = 0;
        res.status = ST_OK;
      end
      default: begin
        res.status = ST_BADPOS;
      end
    endcase
    res.item_count = 8'(shadow_count);
    res.is_empty   = (shadow_count == 0);
    return res;
  endfunction

  // Offers one command, possibly after a random gap, and waits for its
  // transfer. Ready is sampled on the falling edge, where it is settled; a
  // high ready there means the transfer happens on the next rising edge.
  // The task returns on that rising edge, so the next call may drive a new
  // command at once without lowering valid in between.
  task automatic send_command(input logic [CmdWidth-1:0] cmd,
                              input logic [PosWidth-1:0] pos,
                              input logic [DataWidth-1:0] val);
    plt_in_t     item;
    int unsigned gap;
    item.command  = cmd;
    item.position = pos;
    item.value    = val;
    gap = 0;
    while (gap < MaxSendGap && $urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
    end while (in_ready_o !== 1'b1);
    owed_results.push_back(apply_list_command(item));
    @(posedge clk_i);
  endtask

  // Every command that needs a populated list fails cleanly on an empty one,
  // and unknown command codes are rejected.
  task automatic test_empty_list();
    send_command(CMD_DELETE, 8'd1, 32'd0);
    send_command(CMD_OVERWRITE, 8'd1, 32'd5);
    send_command(CMD_READ, 8'd1, 32'd0);
    send_command(CMD_FIND, 8'd0, 32'd0);
    send_command(CMD_INSERT, 8'd0, 32'd9);
    send_command(CMD_INSERT, 8'd2, 32'd9);
    send_command(CMD_CLEAR, 8'd0, 32'd0);
    send_command(3'd6, 8'd1, 32'hFFFF_FFFF);
    send_command(3'd7, 8'd0, 32'd0);
  endtask

  // Extreme values, positions at and past both ends of the list, a find
  // that must report the first of two matches, and a find with no match.
  task automatic test_edge_values();
    send_command(CMD_INSERT, 8'd1, 32'h8000_0000);
    send_command(CMD_INSERT, 8'd2, 32'h7FFF_FFFF);
    send_command(CMD_INSERT, 8'd1, 32'hFFFF_FFFF);
    send_command(CMD_INSERT, 8'd4, 32'd0);
    send_command(CMD_INSERT, 8'd6, 32'd1);
    send_command(CMD_READ, 8'd1, 32'd0);
    send_command(CMD_READ, 8'd2, 32'd0);
    send_command(CMD_READ, 8'd4, 32'd0);
    send_command(CMD_READ, 8'd5, 32'd0);
    send_command(CMD_READ, 8'd255, 32'd0);
    send_command(CMD_FIND, 8'd0, 32'h7FFF_FFFF);
    send_command(CMD_OVERWRITE, 8'd4, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, 32'hFFFF_FFFF);
    send_command(CMD_FIND, 8'd0, 32'd42);
    send_command(CMD_DELETE, 8'd2, 32'd0);
    send_command(CMD_DELETE, 8'd4, 32'd0);
    send_command(CMD_OVERWRITE, 8'd0, 32'd3);
    send_command(CMD_CLEAR, 8'd0, 32'd0);
  endtask

  // Fills the list to capacity at random positions, then probes the full
  // list: inserts that are rejected as full, one of them just past the end,
  // one two past the end that is a bad position, and the last entry itself.
  task automatic test_fill_to_capacity();
    send_command(CMD_CLEAR, 8'd0, 32'd0);
    while (shadow_count < ListDepth) begin
      send_command(CMD_INSERT, 8'($urandom_range(shadow_count + 1, 1)), $urandom);
    end
    send_command(CMD_INSERT, 8'(ListDepth + 1), $urandom);
    send_command(CMD_INSERT, 8'd1, $urandom);
    send_command(CMD_INSERT, 8'(ListDepth + 2), $urandom);
    send_command(CMD_READ, 8'(ListDepth), 32'd0);
    send_command(CMD_FIND, 8'd0, shadow_list[ListDepth-1]);
    send_command(CMD_DELETE, 8'(ListDepth), 32'd0);
    send_command(CMD_INSERT, 8'(ListDepth), $urandom);
  endtask

  // The receiver holds off for a long stretch while commands keep coming
  // back to back, so the block fills up and must stall its input.
  task automatic test_output_backpressure();
    int unsigned i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (i = 0; i < 40; i++) begin
      send_command(CMD_INSERT, 8'($urandom_range(shadow_count + 1, 1)), $urandom);
    end
  endtask

  // Random commands. Most positions fall inside the list, so commands reach
  // the shifting logic, and many values are repeats of stored entries or
  // small numbers, so that finds hit and duplicates occur.
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned          i;
    int unsigned          pick;
    int unsigned          vsel;
    logic [CmdWidth-1:0]  cmd;
    logic [PosWidth-1:0]  pos;
    logic [DataWidth-1:0] val;
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      if (pick < 28) begin
        cmd = CMD_INSERT;
      end else if (pick < 48) begin
        cmd = CMD_DELETE;
      end else if (pick < 60) begin
        cmd = CMD_OVERWRITE;
      end else if (pick < 78) begin
        cmd = CMD_READ;
      end else if (pick < 95) begin
        cmd = CMD_FIND;
      end else if (pick < 97) begin
        cmd = CMD_CLEAR;
      end else begin
        cmd = 3'($urandom_range(7, 6));
      end
      vsel = $urandom_range(3);
      val = $urandom;
      if (vsel == 0) begin
        val = $urandom_range(3);
      end else if (vsel == 1 && shadow_count > 0) begin
        val = shadow_list[$urandom_range(shadow_count - 1)];
      end
      if ($urandom_range(99) < 12) begin
        pos = 8'($urandom_range(255));
      end else begin
        pos = 8'($urandom_range(shadow_count + 1, 1));
      end
      send_command(cmd, pos, val);
    end
  endtask

  // Result side: the ready pattern is chosen on each rising edge. A long
  // hold-off, once requested, is counted down here.
  initial begin : result_sink
    int unsigned hold_served;
    int unsigned stall_left;
    hold_served = 0;
    stall_left  = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left  = LongHoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Checks every result transfer. Like ready on the input side, valid and
  // ready are sampled on the falling edge ahead of the transfer edge.
  always @(negedge clk_i) begin : result_check
    plt_out_t exp_r;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatch_count++;
      end else begin
        exp_r = owed_results.pop_front();
        if (out_data_o.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_data_o.status);
          mismatch_count++;
        end
        if (out_data_o.read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, actual %0d",
                 exp_r.read_value, out_data_o.read_value);
          mismatch_count++;
        end
        if (out_data_o.found_position !== exp_r.found_position) begin
          $error("found_position: expected %0d, actual %0d",
                 exp_r.found_position, out_data_o.found_position);
          mismatch_count++;
        end
        if (out_data_o.item_count !== exp_r.item_count) begin
          $error("item_count: expected %0d, actual %0d",
                 exp_r.item_count, out_data_o.item_count);
          mismatch_count++;
        end
        if (out_data_o.is_empty !== exp_r.is_empty) begin
          $error("is_empty: expected %0d, actual %0d", exp_r.is_empty, out_data_o.is_empty);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding",
           cycle_count, owed_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Test sequence. Reset is held first; then the directed tests run with a
  // slow receiver, the random mixes run under each idle pattern, and the fill
  // and back-pressure tests run with neither side idling.
  initial begin : test_sequence
    mismatch_count = 0;
    shadow_count   = 0;
    hold_requests  = 0;
    send_idle_pct  = 31;
    recv_idle_pct  = 62;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_list();
    test_edge_values();
    test_random_mix(200);

    send_idle_pct = 62;
    recv_idle_pct = 31;
    test_random_mix(200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_mix(100);

    in_valid_i <= 1'b0;
    wait (owed_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
